>>> src/psar_pkg.sv
// shared constants and types for the parabolic stop-and-reverse block
package psar_pkg;

  localparam int PRICE_BITS_DEF   = 32;
  localparam int AF_FRAC_BITS_DEF = 16;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_AF_STEP       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AF_MAX        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTRADAY_MODE = 2'd2;

  localparam int AF_STEP_RESET = 1311;
  localparam int AF_MAX_RESET  = 13107;

  typedef struct packed {
    logic day_changed;
    logic series_start;
  } bar_flags_t;

  typedef struct packed {
    logic series_active;
    logic trend_short;
  } trend_flags_t;

endpackage

>>> src/psar_advance.sv
// moves the level toward the extreme point by the factor, floor and saturation
module psar_advance #(
  parameter int PRICE_BITS   = psar_pkg::PRICE_BITS_DEF,
  parameter int AF_FRAC_BITS = psar_pkg::AF_FRAC_BITS_DEF
) (
  input  logic [PRICE_BITS-1:0]   cur,
  input  logic [PRICE_BITS-1:0]   ep,
  input  logic [AF_FRAC_BITS:0]   af,
  output logic [PRICE_BITS-1:0]   lvl
);

  localparam int AF_W   = AF_FRAC_BITS + 1;
  localparam int PROD_W = PRICE_BITS + AF_W;
  localparam int Q_W    = PROD_W - AF_FRAC_BITS;
  localparam int SUM_W  = PRICE_BITS + 2;

  logic                  neg;
  logic [PRICE_BITS-1:0] mag;
  logic [PROD_W-1:0]     prod;
  logic [Q_W-1:0]        q;
  logic                  rem;
  logic [SUM_W-1:0]      up_sum;
  logic [SUM_W-1:0]      down_q;

  always_comb begin
    neg    = ep < cur;
    mag    = neg ? (cur - ep) : (ep - cur);
    prod   = PROD_W'(mag) * PROD_W'(af);
    q      = prod[PROD_W-1:AF_FRAC_BITS];
    rem    = |prod[AF_FRAC_BITS-1:0];
    up_sum = SUM_W'(cur) + SUM_W'(q);
    down_q = SUM_W'(q) + SUM_W'(rem);
    if (!neg) begin
      lvl = (|up_sum[SUM_W-1:PRICE_BITS]) ? {PRICE_BITS{1'b1}} : up_sum[PRICE_BITS-1:0];
    end else begin
      lvl = (down_q > SUM_W'(cur)) ? '0 : (cur - down_q[PRICE_BITS-1:0]);
    end
  end

endmodule

>>> src/psar_step.sv
// next-state logic for one bar: restart, extreme tracking, clamps and reversal
module psar_step #(
  parameter int PRICE_BITS   = psar_pkg::PRICE_BITS_DEF,
  parameter int AF_FRAC_BITS = psar_pkg::AF_FRAC_BITS_DEF
) (
  input  logic [AF_FRAC_BITS-1:0] af_step,
  input  logic [AF_FRAC_BITS-1:0] af_max,
  input  logic                    intraday_mode,
  input  psar_pkg::bar_flags_t    flags,
  input  logic [PRICE_BITS-1:0]   bar_high,
  input  logic [PRICE_BITS-1:0]   bar_low,
  input  psar_pkg::trend_flags_t  st,
  input  logic [AF_FRAC_BITS:0]   accel_factor,
  input  logic [PRICE_BITS-1:0]   stop_level,
  input  logic [PRICE_BITS-1:0]   extreme_point,
  input  logic [PRICE_BITS-1:0]   prior_low,
  input  logic [PRICE_BITS-1:0]   prior_high,
  output logic                    trend_short_next,
  output logic [AF_FRAC_BITS:0]   accel_factor_next,
  output logic [PRICE_BITS-1:0]   stop_level_next,
  output logic [PRICE_BITS-1:0]   extreme_point_next
);

  localparam int AF_W = AF_FRAC_BITS + 1;

  logic                  restart;
  logic [AF_W-1:0]       af_grown;
  logic [PRICE_BITS-1:0] adv;
  logic                  new_hi;
  logic                  new_lo;
  logic [PRICE_BITS-1:0] ep_l;
  logic [PRICE_BITS-1:0] ep_s;
  logic [AF_W-1:0]       af_l;
  logic [AF_W-1:0]       af_s;
  logic [PRICE_BITS-1:0] lo_min;
  logic [PRICE_BITS-1:0] hi_max;
  logic [PRICE_BITS-1:0] clamp_l;
  logic [PRICE_BITS-1:0] clamp_s;
  logic [PRICE_BITS-1:0] lvl_l;
  logic [PRICE_BITS-1:0] lvl_s;
  logic                  rev_l;
  logic                  rev_s;

  psar_advance #(
    .PRICE_BITS  (PRICE_BITS),
    .AF_FRAC_BITS(AF_FRAC_BITS)
  ) u_advance (
    .cur(stop_level),
    .ep (extreme_point),
    .af (accel_factor),
    .lvl(adv)
  );

  always_comb begin
    restart  = flags.series_start || !st.series_active || (intraday_mode && flags.day_changed);
    af_grown = (accel_factor < {1'b0, af_max}) ? (accel_factor + AF_W'(af_step)) : accel_factor;

    // long side
    new_hi  = bar_high > extreme_point;
    ep_l    = new_hi ? bar_high : extreme_point;
    af_l    = new_hi ? af_grown : accel_factor;
    lo_min  = (bar_low < prior_low) ? bar_low : prior_low;
    clamp_l = (lo_min < adv) ? lo_min : adv;
    lvl_l   = (stop_level > clamp_l) ? stop_level : clamp_l;
    rev_l   = bar_low < lvl_l;

    // short side
    new_lo  = bar_low < extreme_point;
    ep_s    = new_lo ? bar_low : extreme_point;
    af_s    = new_lo ? af_grown : accel_factor;
    hi_max  = (bar_high > prior_high) ? bar_high : prior_high;
    clamp_s = (hi_max > adv) ? hi_max : adv;
    lvl_s   = (stop_level < clamp_s) ? stop_level : clamp_s;
    rev_s   = bar_high > lvl_s;

    if (restart) begin
      trend_short_next   = 1'b0;
      accel_factor_next  = AF_W'(af_step);
      stop_level_next    = bar_low;
      extreme_point_next = bar_high;
    end else if (!st.trend_short) begin
      if (rev_l) begin
        trend_short_next   = 1'b1;
        accel_factor_next  = AF_W'(af_step);
        stop_level_next    = ep_l;
        extreme_point_next = bar_low;
      end else begin
        trend_short_next   = 1'b0;
        accel_factor_next  = af_l;
        stop_level_next    = lvl_l;
        extreme_point_next = ep_l;
      end
    end else begin
      if (rev_s) begin
        trend_short_next   = 1'b0;
        accel_factor_next  = AF_W'(af_step);
        stop_level_next    = ep_s;
        extreme_point_next = bar_high;
      end else begin
        trend_short_next   = 1'b1;
        accel_factor_next  = af_s;
        stop_level_next    = lvl_s;
        extreme_point_next = ep_s;
      end
    end
  end

endmodule

>>> src/parabolic_stop_and_reverse.sv
// top level of the parabolic stop-and-reverse block
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tdata: bar_high, bar_low; tuser: series_start, day_changed
// m_*      out  m_tvalid/m_tready  tdata: sar_level
// cfg_*    in   cfg_we             cfg_index, cfg_data
//
// one bar per cycle sustained while m_tready holds; a bar passes the input register, then the result register
// the input register feeds the step logic, whose one multiplier and compares set the cycle
// state and the result register update together, so the next bar sees the new state at once
// rst clears config to defaults, the trend state and both valid flags
// a stalled result holds while one more bar waits in the input register
module parabolic_stop_and_reverse #(
  parameter int PRICE_BITS   = psar_pkg::PRICE_BITS_DEF,
  parameter int AF_FRAC_BITS = psar_pkg::AF_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [psar_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [AF_FRAC_BITS-1:0]           cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // bar_high, bar_low, zero pad
  input  logic [((2*PRICE_BITS+7)/8)*8-1:0] s_tdata,
  // series_start, day_changed
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // sar_level, zero pad
  output logic [((PRICE_BITS+7)/8)*8-1:0]   m_tdata
);

  localparam int M_W  = ((PRICE_BITS + 7) / 8) * 8;
  localparam int AF_W = AF_FRAC_BITS + 1;

  logic [AF_FRAC_BITS-1:0] af_step;
  logic [AF_FRAC_BITS-1:0] af_max;
  logic                    intraday_mode;

  logic                    in_valid;
  logic [PRICE_BITS-1:0]   in_high;
  logic [PRICE_BITS-1:0]   in_low;
  psar_pkg::bar_flags_t    in_flags;

  psar_pkg::trend_flags_t  st;
  logic [AF_W-1:0]         accel_factor;
  logic [PRICE_BITS-1:0]   stop_level;
  logic [PRICE_BITS-1:0]   extreme_point;
  logic [PRICE_BITS-1:0]   prior_low;
  logic [PRICE_BITS-1:0]   prior_high;

  logic                    trend_short_next;
  logic [AF_W-1:0]         accel_factor_next;
  logic [PRICE_BITS-1:0]   stop_level_next;
  logic [PRICE_BITS-1:0]   extreme_point_next;

  logic [PRICE_BITS-1:0]   out_level;
  logic                    advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !rst && (!in_valid || advance);
  assign m_tdata  = M_W'(out_level);

  always_ff @(posedge clk) begin
    if (rst) begin
      af_step       <= AF_FRAC_BITS'(psar_pkg::AF_STEP_RESET);
      af_max        <= AF_FRAC_BITS'(psar_pkg::AF_MAX_RESET);
      intraday_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        psar_pkg::CFG_AF_STEP:       af_step       <= cfg_data;
        psar_pkg::CFG_AF_MAX:        af_max        <= cfg_data;
        psar_pkg::CFG_INTRADAY_MODE: intraday_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_high  <= s_tdata[PRICE_BITS-1:0];
      in_low   <= s_tdata[2*PRICE_BITS-1:PRICE_BITS];
      in_flags <= psar_pkg::bar_flags_t'(s_tuser);
    end
  end

  psar_step #(
    .PRICE_BITS  (PRICE_BITS),
    .AF_FRAC_BITS(AF_FRAC_BITS)
  ) u_step (
    .af_step           (af_step),
    .af_max            (af_max),
    .intraday_mode     (intraday_mode),
    .flags             (in_flags),
    .bar_high          (in_high),
    .bar_low           (in_low),
    .st                (st),
    .accel_factor      (accel_factor),
    .stop_level        (stop_level),
    .extreme_point     (extreme_point),
    .prior_low         (prior_low),
    .prior_high        (prior_high),
    .trend_short_next  (trend_short_next),
    .accel_factor_next (accel_factor_next),
    .stop_level_next   (stop_level_next),
    .extreme_point_next(extreme_point_next)
  );

  // trend state
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= '0;
      accel_factor  <= '0;
      stop_level    <= '0;
      extreme_point <= '0;
      prior_low     <= '0;
      prior_high    <= '0;
    end else if (advance) begin
      st.trend_short   <= trend_short_next;
      st.series_active <= 1'b1;
      accel_factor     <= accel_factor_next;
      stop_level       <= stop_level_next;
      extreme_point    <= extreme_point_next;
      prior_low        <= in_low;
      prior_high       <= in_high;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_level <= stop_level_next;
    end
  end

endmodule

>>> src/psar_checker.sv
// port-level assertions for the parabolic stop-and-reverse block, with its bind
module psar_checker #(
  parameter int PRICE_BITS = psar_pkg::PRICE_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [((PRICE_BITS+7)/8)*8-1:0] m_tdata
);

  localparam int M_W = ((PRICE_BITS + 7) / 8) * 8;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && !s_tready || !rst)
    else $error("result valid right after reset");

  // a new result comes from an earlier accepted input transaction
  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a matching input transaction");

  // input only blocks when the output side is full and stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with output free");

  // pad bits above the level stay zero
  if (M_W > PRICE_BITS) begin : g_pad
    a_pad: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> m_tdata[M_W-1:PRICE_BITS] == '0)
      else $error("nonzero pad in result");
  end

endmodule

bind parabolic_stop_and_reverse psar_checker #(
  .PRICE_BITS(PRICE_BITS)
) u_psar_checker (.*);
